[rtl/core/pid_steer_windowed_integral_unit_macros.svh]
// ---------------------------------------------------------------------------
// PID steering unit assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_STEER_WINDOWED_INTEGRAL_UNIT_MACROS_SVH
`define PID_STEER_WINDOWED_INTEGRAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSWI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pswi: same-cycle check failed");

// next-cycle implication
`define PSWI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pswi: next-cycle check failed");

`else

`define PSWI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PSWI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/pswi_pkg.sv]
// ---------------------------------------------------------------------------
// PID steering unit package
// Field widths, fixed-point constants, codes and pipeline stage types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pswi_pkg;

    localparam int ERR_W    = 16;   // Q4.12 error sample
    localparam int GAIN_W   = 16;   // Q4.12 gains
    localparam int DIFF_W   = 17;   // e - prev
    localparam int SUM_W    = 24;   // window sum, wraps
    localparam int PROP_W   = 32;
    localparam int DER_W    = 33;
    localparam int INT_W    = 40;
    localparam int TOTAL_W  = 42;   // Q.24 sum of the three products
    localparam int STEER_W  = 16;   // Q2.14
    localparam int MAG_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam int DEFAULT_WINDOW_DEPTH = 100;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KP = 2'd0;
    localparam t_cfg_idx CFG_KI = 2'd1;
    localparam t_cfg_idx CFG_KD = 2'd2;

    typedef enum logic [1:0] {
        THR_0P1 = 2'd0,
        THR_0P3 = 2'd1,
        THR_0P4 = 2'd2,
        THR_0P5 = 2'd3
    } t_throttle;

    // +-1.0 in Q.24 and in Q2.14
    localparam logic signed [TOTAL_W-1:0] CLIP_BOUND = 42'sd16777216;
    localparam logic signed [STEER_W-1:0] STEER_ONE  = 16'sd16384;

    // Q.24 -> Q2.14, round half up
    localparam logic signed [TOTAL_W-1:0] ROUND_BIAS = 42'sd512;
    localparam int FRAC_SHIFT = 10;

    // 0.3, 0.2, 0.1 in Q2.14
    localparam logic [MAG_W-1:0] THR_HI  = 15'd4915;
    localparam logic [MAG_W-1:0] THR_MID = 15'd3276;
    localparam logic [MAG_W-1:0] THR_LO  = 15'd1638;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  sum;
    } t_operands;

    typedef struct packed {
        logic signed [PROP_W-1:0] prop;
        logic signed [DER_W-1:0]  der;
        logic signed [INT_W-1:0]  integ;
    } t_products;

endpackage

[rtl/core/pid_steer_windowed_integral_unit.sv]
// ---------------------------------------------------------------------------
// PID steering unit with windowed integral
// Steer command and throttle level from a cross-track error stream.
// ---------------------------------------------------------------------------
// One error sample (Q4.12) per request in, one steer command (Q2.14, clamped
// to +-1.0, with a clip flag) and a throttle level per request out. The unit
// takes a new request every cycle while the output is not stalled; a result
// passes the operand, product, total and output registers. That rate is set
// by the window ring: the oldest sample is kept ready in a registered read
// of the ring memory, so the running sum is updated once per request with a
// single add and subtract. Stalls on the output back up the stage registers
// one at a time, so bubbles are squeezed out before input is held off.
// The user must write gains through the config port only while the unit is
// idle; the unit does not enforce it. Any gain write re-arms the first-sample
// rule (next sample's derivative term is zero); ring contents survive it.
// No clearing pass after reset: ring entries are only read once written.
`timescale 1ns / 1ps

`include "pid_steer_windowed_integral_unit_macros.svh"

module pid_steer_windowed_integral_unit #(
    parameter int WINDOW_DEPTH = pswi_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write port
    input  logic                                   i_cfg_we,
    input  logic [pswi_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pswi_pkg::GAIN_W-1:0]            i_cfg_data,
    // sample request
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pswi_pkg::ERR_W-1:0]      i_error_sample,
    // result
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pswi_pkg::STEER_W-1:0]    o_steer,
    output logic                                   o_steer_clipped,
    output logic [1:0]                             o_throttle_level
);
    import pswi_pkg::*;

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_DEPTH);

    // ---------------- gain registers ----------------
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic                     cfg_hit;

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_idx == CFG_KP || i_cfg_idx == CFG_KI || i_cfg_idx == CFG_KD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:  r_kp <= i_cfg_data;
                CFG_KI:  r_ki <= i_cfg_data;
                CFG_KD:  r_kd <= i_cfg_data;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic rdy_out, rdy3, rdy2, rdy1;
    logic in_acc;

    // each stage moves when it is empty or its successor moves
    assign rdy_out = !r_out_valid || i_out_ready;
    assign rdy3    = !r_v3 || rdy_out;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;

    assign o_in_ready = rdy1;
    assign in_acc     = i_in_valid && rdy1;

    // ---------------- window ring and running state ----------------
    logic signed [ERR_W-1:0] mem [WINDOW_DEPTH];
    logic signed [ERR_W-1:0] r_oldest;     // mem[r_slot], registered read
    logic [SLOT_W-1:0]       r_slot, n_slot, slot_adv, rd_addr;
    logic [FILL_W-1:0]       r_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [ERR_W-1:0] r_prev, prev_eff;
    logic                    r_first;
    logic                    full;
    logic signed [DIFF_W-1:0] n_diff;

    assign full     = (r_fill == FULL_FILL);
    assign slot_adv = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
    assign n_slot   = in_acc ? slot_adv : r_slot;
    assign rd_addr  = n_slot;

    // first sample after reset or a gain write: derivative term is zero
    assign prev_eff = r_first ? i_error_sample : r_prev;
    assign n_diff   = DIFF_W'(i_error_sample) - DIFF_W'(prev_eff);

    // full window drops the oldest sample as the new one enters
    assign n_sum = r_sum - (full ? SUM_W'(r_oldest) : '0) + SUM_W'(i_error_sample);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_slot] <= i_error_sample;
        end
        // forward on read-during-write (single-entry window)
        if (in_acc && rd_addr == r_slot) begin
            r_oldest <= i_error_sample;
        end else begin
            r_oldest <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_prev  <= '0;
            r_first <= 1'b1;
        end else begin
            if (in_acc) begin
                r_slot <= n_slot;
                r_sum  <= n_sum;
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (cfg_hit) begin
                r_prev  <= '0;
                r_first <= 1'b1;
            end else if (in_acc) begin
                r_prev  <= i_error_sample;
                r_first <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: operands ----------------
    t_operands r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.err  <= i_error_sample;
            r_s1.diff <= n_diff;
            r_s1.sum  <= n_sum;
        end
    end

    // ---------------- stage 2: products ----------------
    t_products r_s2;
    t_products n_s2;

    always_comb begin
        n_s2.prop  = PROP_W'(r_kp) * PROP_W'(r_s1.err);
        n_s2.der   = DER_W'(r_kd) * DER_W'(r_s1.diff);
        n_s2.integ = INT_W'(r_ki) * INT_W'(r_s1.sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- stage 3: total ----------------
    logic signed [TOTAL_W-1:0] r_total, n_total;

    assign n_total = TOTAL_W'(r_s2.prop) + TOTAL_W'(r_s2.der) + TOTAL_W'(r_s2.integ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_total <= n_total;
        end
    end

    // ---------------- output stage: clamp, round, throttle ----------------
    logic signed [TOTAL_W-1:0] neg, biased;
    logic signed [STEER_W-1:0] n_steer;
    logic                      n_clip;
    logic [MAG_W-1:0]          mag;
    t_throttle                 n_level;
    logic signed [STEER_W-1:0] r_steer;
    logic                      r_clip;
    t_throttle                 r_level;

    always_comb begin
        neg    = -r_total;
        biased = neg + ROUND_BIAS;
        if (neg > CLIP_BOUND) begin
            n_steer = STEER_ONE;
            n_clip  = 1'b1;
        end else if (neg < -CLIP_BOUND) begin
            n_steer = -STEER_ONE;
            n_clip  = 1'b1;
        end else begin
            n_steer = biased[FRAC_SHIFT +: STEER_W];
            n_clip  = 1'b0;
        end
        mag = n_steer[STEER_W-1] ? MAG_W'(-n_steer) : MAG_W'(n_steer);
        if (mag > THR_HI) begin
            n_level = THR_0P1;
        end else if (mag > THR_MID) begin
            n_level = THR_0P3;
        end else if (mag > THR_LO) begin
            n_level = THR_0P4;
        end else begin
            n_level = THR_0P5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v3) begin
            r_steer <= n_steer;
            r_clip  <= n_clip;
            r_level <= n_level;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_steer          = r_steer;
    assign o_steer_clipped  = r_clip;
    assign o_throttle_level = r_level;

    // ---------------- assertions ----------------
    // until the ring fills, the write slot tracks the fill count
    `PSWI_ASSERT_NOW(a_slot_tracks_fill, i_clk, i_rst_n, (r_fill != FULL_FILL), (r_slot == SLOT_W'(r_fill)))
    // a gain write re-arms the first-sample rule
    `PSWI_ASSERT_NEXT(a_cfg_rearms, i_clk, i_rst_n, cfg_hit, (r_first && r_prev == '0))
    // a clipped result sits exactly on the rail
    `PSWI_ASSERT_NOW(a_clip_on_rail, i_clk, i_rst_n, (o_out_valid && o_steer_clipped), (o_steer == STEER_ONE || o_steer == -STEER_ONE))
    // a clipped result always asks for the lowest throttle
    `PSWI_ASSERT_NOW(a_clip_throttle, i_clk, i_rst_n, (o_out_valid && o_steer_clipped), (o_throttle_level == THR_0P1))

endmodule
